// ----- rtl/asq_pkg.sv -----
// Shared types and constants for the eight-way stick quantizer.
package asq_pkg;

  localparam int AXIS_BITS = 8;
  localparam int DZ_BITS   = 7;
  localparam int LIM_BITS  = 8;
  localparam int DZ_W      = (AXIS_BITS > DZ_BITS) ? AXIS_BITS : DZ_BITS;
  localparam int LK_W      = AXIS_BITS + 5;
  localparam int SQ_W      = 2 * AXIS_BITS;
  localparam int LSQ_W     = 2 * LIM_BITS;
  localparam int CMP_W     = ((SQ_W + 2) > LSQ_W) ? (SQ_W + 2) : LSQ_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int OUT_W     = 8;
  localparam int MODE_W    = 16;

  typedef logic [AXIS_BITS-1:0] mag_t;
  typedef logic [DZ_W-1:0]      dz_cmp_t;
  typedef logic [LK_W-1:0]      lk_t;
  typedef logic [SQ_W-1:0]      sq_t;
  typedef logic [LSQ_W-1:0]     lsq_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_DZ   = 2'd0,
    REG_RADIAL_DZ = 2'd1,
    REG_WALK_LIM  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DZ_BITS-1:0]  axis_dz;
    logic [LIM_BITS-1:0] radial_dz;
    logic [LIM_BITS-1:0] walk_lim;
  } cfg_t;

  localparam logic [DZ_BITS-1:0]  AXIS_DZ_RST   = 7'd18;
  localparam logic [LIM_BITS-1:0] RADIAL_DZ_RST = 8'd8;
  localparam logic [LIM_BITS-1:0] WALK_LIM_RST  = 8'd80;

  localparam logic signed [OUT_W-1:0] WALK_SPEED = 8'sd64;
  localparam logic signed [OUT_W-1:0] RUN_SPEED  = 8'sd127;
  localparam logic signed [OUT_W-1:0] WALK_DIAG  = 8'sd45;
  localparam logic signed [OUT_W-1:0] RUN_DIAG   = 8'sd89;
  localparam logic signed [OUT_W-1:0] AIM_SPEED  = 8'sd127;

  localparam logic [MODE_W-1:0] AIM_MODE_A = 16'd5;
  localparam logic [MODE_W-1:0] AIM_MODE_B = 16'd7;
  localparam logic [MODE_W-1:0] AIM_MODE_C = 16'd8;
  localparam logic [MODE_W-1:0] AIM_MODE_D = 16'd16;
  localparam logic [MODE_W-1:0] AIM_MODE_E = 16'd53;
  localparam logic [MODE_W-1:0] AIM_MODE_F = 16'd65;

endpackage

// ----- rtl/asq_pipe.sv -----
// Four-stage datapath: deadzone, axis lock, squares, sector select.
module asq_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [asq_pkg::AXIS_BITS-1:0] stick_x,
  input  logic signed [asq_pkg::AXIS_BITS-1:0] stick_y,
  input  logic                                present,
  input  logic                                cam_valid,
  input  logic [asq_pkg::MODE_W-1:0]          cam_mode,
  input  asq_pkg::cfg_t                       cfg,
  output logic                                out_valid,
  output logic signed [asq_pkg::OUT_W-1:0]    move_x,
  output logic signed [asq_pkg::OUT_W-1:0]    move_y
);

  // stage 1: abs, per-axis deadzone, aim decode
  logic              v1_r, pres1_r, aim1_r, xn1_r, yn1_r;
  asq_pkg::mag_t     ax1_r, ay1_r;
  asq_pkg::mag_t     ax_raw, ay_raw;
  logic              xz, yz, aim;

  always_comb begin
    ax_raw = stick_x[asq_pkg::AXIS_BITS-1] ? asq_pkg::mag_t'(~stick_x + 1'b1)
                                           : asq_pkg::mag_t'(stick_x);
    ay_raw = stick_y[asq_pkg::AXIS_BITS-1] ? asq_pkg::mag_t'(~stick_y + 1'b1)
                                           : asq_pkg::mag_t'(stick_y);
    xz = asq_pkg::dz_cmp_t'(ax_raw) < asq_pkg::dz_cmp_t'(cfg.axis_dz);
    yz = asq_pkg::dz_cmp_t'(ay_raw) < asq_pkg::dz_cmp_t'(cfg.axis_dz);
    aim = cam_valid && (cam_mode == asq_pkg::AIM_MODE_A || cam_mode == asq_pkg::AIM_MODE_B ||
                        cam_mode == asq_pkg::AIM_MODE_C || cam_mode == asq_pkg::AIM_MODE_D ||
                        cam_mode == asq_pkg::AIM_MODE_E || cam_mode == asq_pkg::AIM_MODE_F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    pres1_r <= present;
    aim1_r  <= aim;
    ax1_r   <= xz ? '0 : ax_raw;
    ay1_r   <= yz ? '0 : ay_raw;
    xn1_r   <= stick_x[asq_pkg::AXIS_BITS-1] && !xz;
    yn1_r   <= stick_y[asq_pkg::AXIS_BITS-1] && !yz;
  end

  // stage 2: lock to one axis when the other is at most 0.35 of it
  logic              v2_r, pres2_r, aim2_r, xn2_r, yn2_r;
  asq_pkg::mag_t     ax2_r, ay2_r;
  logic              lock_y, lock_x;

  always_comb begin
    lock_y = (ax1_r != '0) &&
             (asq_pkg::lk_t'(ay1_r) * asq_pkg::lk_t'(20) <=
              asq_pkg::lk_t'(ax1_r) * asq_pkg::lk_t'(7));
    lock_x = !lock_y && (ay1_r != '0) &&
             (asq_pkg::lk_t'(ax1_r) * asq_pkg::lk_t'(20) <=
              asq_pkg::lk_t'(ay1_r) * asq_pkg::lk_t'(7));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pres2_r <= pres1_r;
    aim2_r  <= aim1_r;
    ax2_r   <= lock_x ? '0 : ax1_r;
    ay2_r   <= lock_y ? '0 : ay1_r;
    xn2_r   <= xn1_r && !lock_x;
    yn2_r   <= yn1_r && !lock_y;
  end

  // stage 3: squares of the axes and limits, x >= y compare
  logic              v3_r, pres3_r, aim3_r, xn3_r, yn3_r, xge3_r;
  asq_pkg::sq_t      sqx3_r, sqy3_r;
  asq_pkg::lsq_t     rdsq3_r, wlsq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    pres3_r <= pres2_r;
    aim3_r  <= aim2_r;
    xn3_r   <= xn2_r;
    yn3_r   <= yn2_r;
    xge3_r  <= ax2_r >= ay2_r;
    sqx3_r  <= asq_pkg::sq_t'(ax2_r) * asq_pkg::sq_t'(ax2_r);
    sqy3_r  <= asq_pkg::sq_t'(ay2_r) * asq_pkg::sq_t'(ay2_r);
    rdsq3_r <= asq_pkg::lsq_t'(cfg.radial_dz) * asq_pkg::lsq_t'(cfg.radial_dz);
    wlsq3_r <= asq_pkg::lsq_t'(cfg.walk_lim) * asq_pkg::lsq_t'(cfg.walk_lim);
  end

  // stage 4: magnitude tests, sector select, output register
  asq_pkg::cmp_t                    mag2, sqx_c, sqy_c;
  logic                             pass, walk, horiz, vert;
  logic signed [asq_pkg::OUT_W-1:0] speed, diag, mx_nxt, my_nxt;
  logic                             ov_r;
  logic signed [asq_pkg::OUT_W-1:0] mx_r, my_r;

  always_comb begin
    sqx_c  = asq_pkg::cmp_t'(sqx3_r);
    sqy_c  = asq_pkg::cmp_t'(sqy3_r);
    mag2   = sqx_c + sqy_c;
    pass   = mag2 >= asq_pkg::cmp_t'(rdsq3_r);
    walk   = mag2 <= asq_pkg::cmp_t'(wlsq3_r);
    horiz  = (sqy_c + sqy_c + sqy_c) <= sqx_c;
    vert   = sqy_c > (sqx_c + sqx_c + sqx_c);
    speed  = walk ? asq_pkg::WALK_SPEED : asq_pkg::RUN_SPEED;
    diag   = walk ? asq_pkg::WALK_DIAG : asq_pkg::RUN_DIAG;
    mx_nxt = '0;
    my_nxt = '0;
    if (pres3_r && pass) begin
      if (aim3_r) begin
        if (xge3_r) begin
          mx_nxt = xn3_r ? -asq_pkg::AIM_SPEED : asq_pkg::AIM_SPEED;
        end else begin
          my_nxt = yn3_r ? -asq_pkg::AIM_SPEED : asq_pkg::AIM_SPEED;
        end
      end else if (horiz) begin
        mx_nxt = xn3_r ? -speed : speed;
      end else if (vert) begin
        my_nxt = yn3_r ? -speed : speed;
      end else begin
        mx_nxt = xn3_r ? -diag : diag;
        my_nxt = yn3_r ? -diag : diag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v3_r;
    end
    mx_r <= mx_nxt;
    my_r <= my_nxt;
  end

  assign out_valid = ov_r;
  assign move_x    = mx_r;
  assign move_y    = my_r;

endmodule

// ----- rtl/analog_stick_eight_way_quantizer.sv -----
// Top level of the eight-way analog stick quantizer with its config registers.
//
// Usage:
//   Input: drive the in_ fields and raise start; a transfer happens at each
//   rising edge with start high and busy low. busy is always low, so one
//   sample can be taken every cycle.
//   Output: each sample gives one result on move_x/move_y, marked by a
//   one-cycle out_valid pulse, after its transfer passes the four register
//   stages (deadzone, axis lock, squaring multipliers, sector compare).
//   Throughput is one sample per cycle, as no stage stalls.
//   Config: cfg_valid/cfg_ready write channel, cfg_ready always high;
//   index 0 axis deadzone, 1 radial deadzone, 2 walk limit; other indexes
//   are ignored. Write only while no sample is in flight.
//   Reset: synchronous active-low rst_n clears the pipeline valid bits and
//   loads the config defaults (18, 8, 80).
//   The receiver has no stall: results must be taken in their cycle.
module analog_stick_eight_way_quantizer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [asq_pkg::AXIS_BITS-1:0]   in_stick_x,
  input  logic signed [asq_pkg::AXIS_BITS-1:0]   in_stick_y,
  input  logic                                   in_source_present,
  input  logic                                   in_camera_valid,
  input  logic [asq_pkg::MODE_W-1:0]             in_camera_mode,
  output logic                                   out_valid,
  output logic signed [asq_pkg::OUT_W-1:0]       out_move_x,
  output logic signed [asq_pkg::OUT_W-1:0]       out_move_y,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [asq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [asq_pkg::CFG_DAT_W-1:0]          cfg_data
);

  asq_pkg::cfg_t cfg_r;
  logic          accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_dz   <= asq_pkg::AXIS_DZ_RST;
      cfg_r.radial_dz <= asq_pkg::RADIAL_DZ_RST;
      cfg_r.walk_lim  <= asq_pkg::WALK_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        asq_pkg::REG_AXIS_DZ:   cfg_r.axis_dz   <= cfg_data[asq_pkg::DZ_BITS-1:0];
        asq_pkg::REG_RADIAL_DZ: cfg_r.radial_dz <= cfg_data[asq_pkg::LIM_BITS-1:0];
        asq_pkg::REG_WALK_LIM:  cfg_r.walk_lim  <= cfg_data[asq_pkg::LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  asq_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .stick_x   (in_stick_x),
    .stick_y   (in_stick_y),
    .present   (in_source_present),
    .cam_valid (in_camera_valid),
    .cam_mode  (in_camera_mode),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .move_x    (out_move_x),
    .move_y    (out_move_y)
  );

endmodule

// ----- tb/sv/analog_stick_eight_way_quantizer_test.sv -----
// Self-checking testbench for the eight-way stick quantizer: directed table, then randomized phases.
module analog_stick_eight_way_quantizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import asq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DIRECTED_ROWS = 25;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [OUT_W-1:0] mx;
    logic signed [OUT_W-1:0] my;
  } drive_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] sx;
    logic signed [AXIS_BITS-1:0] sy;
    logic present;
    logic cam_ok;
    logic [MODE_W-1:0] mode;
    logic typed;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [AXIS_BITS-1:0] in_stick_x = '0;
  logic signed [AXIS_BITS-1:0] in_stick_y = '0;
  logic in_source_present = 1'b0;
  logic in_camera_valid = 1'b0;
  logic [MODE_W-1:0] in_camera_mode = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_move_x;
  logic signed [OUT_W-1:0] out_move_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic pend_typed = 1'b0;
  logic signed [OUT_W-1:0] pend_ex = '0;
  logic signed [OUT_W-1:0] pend_ey = '0;

  drive_t pending_drive[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int cfg_axis;
  int cfg_radial;
  int cfg_walk;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'sd0,    8'sd0,    1'b1, 1'b0, 16'd0,     1'b1, 8'sd0,   8'sd0},
    '{8'sd127,  8'sd0,    1'b1, 1'b0, 16'd0,     1'b1, 8'sd127, 8'sd0},
    '{-8'sd128, 8'sd0,    1'b1, 1'b0, 16'd0,     1'b1, -8'sd127, 8'sd0},
    '{8'sd0,    8'sd127,  1'b1, 1'b0, 16'd0,     1'b1, 8'sd0,   8'sd127},
    '{8'sd0,    -8'sd128, 1'b1, 1'b0, 16'd0,     1'b1, 8'sd0,   -8'sd127},
    '{8'sd127,  8'sd127,  1'b1, 1'b0, 16'd0,     1'b1, 8'sd89,  8'sd89},
    '{-8'sd128, -8'sd128, 1'b1, 1'b0, 16'd0,     1'b1, -8'sd89, -8'sd89},
    '{8'sd127,  -8'sd128, 1'b1, 1'b0, 16'd0,     1'b1, 8'sd89,  -8'sd89},
    '{8'sd127,  8'sd127,  1'b0, 1'b0, 16'd0,     1'b1, 8'sd0,   8'sd0},
    '{8'sd17,   8'sd17,   1'b1, 1'b0, 16'd0,     1'b1, 8'sd0,   8'sd0},
    '{8'sd40,   8'sd40,   1'b1, 1'b0, 16'd0,     1'b1, 8'sd45,  8'sd45},
    '{8'sd100,  8'sd35,   1'b1, 1'b0, 16'd0,     1'b0, 8'sd0,   8'sd0},
    '{8'sd35,   -8'sd100, 1'b1, 1'b0, 16'd0,     1'b0, 8'sd0,   8'sd0},
    '{8'sd100,  -8'sd50,  1'b1, 1'b1, 16'd5,     1'b1, 8'sd127, 8'sd0},
    '{-8'sd50,  8'sd100,  1'b1, 1'b1, 16'd7,     1'b1, 8'sd0,   8'sd127},
    '{8'sd0,    -8'sd127, 1'b1, 1'b1, 16'd8,     1'b0, 8'sd0,   8'sd0},
    '{-8'sd127, -8'sd60,  1'b1, 1'b1, 16'd16,    1'b0, 8'sd0,   8'sd0},
    '{8'sd60,   8'sd60,   1'b1, 1'b1, 16'd53,    1'b0, 8'sd0,   8'sd0},
    '{-8'sd90,  8'sd90,   1'b1, 1'b1, 16'd65,    1'b0, 8'sd0,   8'sd0},
    '{8'sd100,  -8'sd50,  1'b1, 1'b0, 16'd5,     1'b0, 8'sd0,   8'sd0},
    '{8'sd100,  -8'sd50,  1'b1, 1'b1, 16'd6,     1'b0, 8'sd0,   8'sd0},
    '{8'sd100,  -8'sd50,  1'b1, 1'b1, 16'd65535, 1'b0, 8'sd0,   8'sd0},
    '{8'sd18,   8'sd0,    1'b1, 1'b0, 16'd0,     1'b0, 8'sd0,   8'sd0},
    '{8'sd20,   8'sd11,   1'b1, 1'b0, 16'd0,     1'b0, 8'sd0,   8'sd0},
    '{-8'sd1,   -8'sd1,   1'b1, 1'b0, 16'd0,     1'b0, 8'sd0,   8'sd0}
  };

  analog_stick_eight_way_quantizer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_stick_x        (in_stick_x),
    .in_stick_y        (in_stick_y),
    .in_source_present (in_source_present),
    .in_camera_valid   (in_camera_valid),
    .in_camera_mode    (in_camera_mode),
    .out_valid         (out_valid),
    .out_move_x        (out_move_x),
    .out_move_y        (out_move_y),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic drive_t predict_drive(input logic signed [AXIS_BITS-1:0] sx,
                                           input logic signed [AXIS_BITS-1:0] sy,
                                           input logic present, input logic cam_ok,
                                           input logic [MODE_W-1:0] mode);
    int x, y, ax, ay, mag2, spd, dg, ox, oy;
    logic aim;
    drive_t r;
    x = int'(sx);
    y = int'(sy);
    ox = 0;
    oy = 0;
    if (present) begin
      if (iabs(x) < cfg_axis) x = 0;
      if (iabs(y) < cfg_axis) y = 0;
      ax = iabs(x);
      ay = iabs(y);
      if (ax > 0 && 20 * ay <= 7 * ax) y = 0;
      if (ay > 0 && 20 * ax <= 7 * ay) x = 0;
      ax = iabs(x);
      ay = iabs(y);
      mag2 = ax * ax + ay * ay;
      aim = cam_ok && (mode == AIM_MODE_A || mode == AIM_MODE_B || mode == AIM_MODE_C ||
                       mode == AIM_MODE_D || mode == AIM_MODE_E || mode == AIM_MODE_F);
      if (mag2 >= cfg_radial * cfg_radial) begin
        if (aim) begin
          if (ax >= ay) ox = (x >= 0) ? int'(AIM_SPEED) : -int'(AIM_SPEED);
          else oy = (y >= 0) ? int'(AIM_SPEED) : -int'(AIM_SPEED);
        end else begin
          spd = (mag2 <= cfg_walk * cfg_walk) ? int'(WALK_SPEED) : int'(RUN_SPEED);
          dg = spd * 7071 / 10000;
          if (3 * ay * ay <= ax * ax) begin
            ox = (x >= 0) ? spd : -spd;
          end else if (ay * ay > 3 * ax * ax) begin
            oy = (y >= 0) ? spd : -spd;
          end else begin
            ox = (x >= 0) ? dg : -dg;
            oy = (y >= 0) ? dg : -dg;
          end
        end
      end
    end
    r.mx = ox[OUT_W-1:0];
    r.my = oy[OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    drive_t exp_drive;
    if (!rst_n) begin
      cfg_axis = int'(AXIS_DZ_RST);
      cfg_radial = int'(RADIAL_DZ_RST);
      cfg_walk = int'(WALK_LIM_RST);
    end else begin
      if (out_valid) begin
        if (pending_drive.size() == 0) begin
          $error("result with no expectation: move_x %0d move_y %0d", out_move_x, out_move_y);
          mismatch_count++;
        end else begin
          exp_drive = pending_drive.pop_front();
          if (out_move_x !== exp_drive.mx) begin
            $error("move_x: expected %0d, actual %0d", exp_drive.mx, out_move_x);
            mismatch_count++;
          end
          if (out_move_y !== exp_drive.my) begin
            $error("move_y: expected %0d, actual %0d", exp_drive.my, out_move_y);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AXIS_DZ:   cfg_axis = int'(cfg_data[DZ_BITS-1:0]);
          REG_RADIAL_DZ: cfg_radial = int'(cfg_data[LIM_BITS-1:0]);
          REG_WALK_LIM:  cfg_walk = int'(cfg_data[LIM_BITS-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (pend_typed) pending_drive.push_back(drive_t'{pend_ex, pend_ey});
        else pending_drive.push_back(predict_drive(in_stick_x, in_stick_y, in_source_present,
                                                   in_camera_valid, in_camera_mode));
      end
    end
  end

  task automatic send_sample(input logic signed [AXIS_BITS-1:0] sx,
                             input logic signed [AXIS_BITS-1:0] sy,
                             input logic present, input logic cam_ok,
                             input logic [MODE_W-1:0] mode, input logic typed,
                             input logic signed [OUT_W-1:0] ex,
                             input logic signed [OUT_W-1:0] ey, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_stick_x <= sx;
    in_stick_y <= sy;
    in_source_present <= present;
    in_camera_valid <= cam_ok;
    in_camera_mode <= mode;
    pend_typed <= typed;
    pend_ex <= ex;
    pend_ey <= ey;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic signed [AXIS_BITS-1:0] boundary_axis();
    int v;
    case ($urandom_range(5))
      0: v = -128;
      1: v = 127;
      2: v = 0;
      3: v = -1;
      default: begin
        v = cfg_axis - 1 + $urandom_range(2);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v[AXIS_BITS-1:0];
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    case ($urandom_range(3))
      0: return MODE_W'($urandom);
      1: return MODE_W'($urandom_range(70));
      default: begin
        case ($urandom_range(5))
          0: return AIM_MODE_A;
          1: return AIM_MODE_B;
          2: return AIM_MODE_C;
          3: return AIM_MODE_D;
          4: return AIM_MODE_E;
          default: return AIM_MODE_F;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic signed [AXIS_BITS-1:0] sx, sy, tmp;
    int major, minor, kind, idle_pct;
    logic [CFG_DAT_W-1:0] axis_val, radial_val, walk_val;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sx, directed_rows[i].sy, directed_rows[i].present,
                  directed_rows[i].cam_ok, directed_rows[i].mode, directed_rows[i].typed,
                  directed_rows[i].ex, directed_rows[i].ey, 8);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin axis_val = 8'd0;   radial_val = 8'd0;   walk_val = 8'd0;   end
        1: begin axis_val = 8'd127; radial_val = 8'd181; walk_val = 8'd181; end
        2: begin axis_val = 8'hFF;  radial_val = 8'hFF;  walk_val = 8'hFF;  end
        3: begin axis_val = 8'd18;  radial_val = 8'd8;   walk_val = 8'd80;  end
        4: begin
          axis_val = CFG_DAT_W'($urandom_range(40));
          radial_val = CFG_DAT_W'($urandom_range(60));
          walk_val = CFG_DAT_W'($urandom_range(181, 20));
        end
        5: begin axis_val = 8'd1;   radial_val = 8'd1;   walk_val = 8'd1;   end
        6: begin
          axis_val = CFG_DAT_W'($urandom);
          radial_val = CFG_DAT_W'($urandom);
          walk_val = CFG_DAT_W'($urandom);
        end
        default: begin axis_val = 8'd5; radial_val = 8'd0; walk_val = 8'd181; end
      endcase
      write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
      write_reg(REG_AXIS_DZ, axis_val);
      write_reg(REG_RADIAL_DZ, radial_val);
      write_reg(REG_WALK_LIM, walk_val);
      cfg_valid <= 1'b0;
      @(posedge clk);

      idle_pct = (p % 4 == 1) ? 64 : ((p % 4 == 3) ? 8 : 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(9);
        if (kind < 4) begin
          sx = AXIS_BITS'($urandom);
          sy = AXIS_BITS'($urandom);
        end else if (kind < 6) begin
          sx = boundary_axis();
          sy = boundary_axis();
        end else begin
          // axis lock and 30-degree sector boundaries
          major = $urandom_range(127, 20);
          if ($urandom_range(1)) minor = (7 * major) / 20 - 1 + $urandom_range(2);
          else minor = (577 * major) / 1000 - 1 + $urandom_range(2);
          sx = major[AXIS_BITS-1:0];
          sy = minor[AXIS_BITS-1:0];
          if ($urandom_range(1)) sx = -sx;
          if ($urandom_range(1)) sy = -sy;
          if ($urandom_range(1)) begin
            tmp = sx;
            sx = sy;
            sy = tmp;
          end
        end
        send_sample(sx, sy, $urandom_range(9) != 0, $urandom_range(3) != 0, pick_mode(),
                    1'b0, '0, '0, idle_pct);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/asq_pkg.sv
rtl/asq_pipe.sv
rtl/analog_stick_eight_way_quantizer.sv
tb/sv/analog_stick_eight_way_quantizer_test.sv
